// ===== sv/cpt_pkg.sv =====
// ----------------------------------------------------------------------------
// cpt_pkg: shared types and widths for the closest-point-on-triangle block
// Item formats, internal word widths and the parameter clamp used by the
// region selection.
// ----------------------------------------------------------------------------
package cpt_pkg;

	localparam int XW = 32;       // coordinate width
	localparam int EW = 33;       // edge and offset vector width
	localparam int DW = 67;       // dot product width
	localparam int HW = 70;       // width of sums of dot products
	localparam int PW = 136;      // width of det, s, t and the region parameters
	localparam int NW = 172;      // width of the rounded numerator
	localparam int QW = 34;       // quotient magnitude bits
	localparam int MUL_SW = 8;    // multiplier digit width, one digit per stage

	typedef struct packed {
		logic signed [XW-1:0] vertex0_x;
		logic signed [XW-1:0] vertex0_y;
		logic signed [XW-1:0] vertex0_z;
		logic signed [XW-1:0] vertex1_x;
		logic signed [XW-1:0] vertex1_y;
		logic signed [XW-1:0] vertex1_z;
		logic signed [XW-1:0] vertex2_x;
		logic signed [XW-1:0] vertex2_y;
		logic signed [XW-1:0] vertex2_z;
		logic signed [XW-1:0] query_x;
		logic signed [XW-1:0] query_y;
		logic signed [XW-1:0] query_z;
	} cpt_in_t;

	typedef struct packed {
		logic signed [XW-1:0] closest_x;
		logic signed [XW-1:0] closest_y;
		logic signed [XW-1:0] closest_z;
	} cpt_out_t;

	typedef struct packed {
		logic signed [HW-1:0] num;
		logic signed [HW-1:0] den;
	} cpt_ratio_t;

	// Limits n/q to [0,1]; a denominator that is not positive gives 0/1.
	function automatic cpt_ratio_t clamp_ratio(logic signed [HW-1:0] n,
		logic signed [HW-1:0] q);
		cpt_ratio_t r;
		r.num = n;
		r.den = q;
		if (q <= 0) begin
			r.num = '0;
			r.den = HW'(1);
		end else if (n <= 0) begin
			r.num = '0;
		end else if (n >= q) begin
			r.num = q;
		end
		return r;
	endfunction

endpackage

// ===== sv/cpt_dly.sv =====
// ----------------------------------------------------------------------------
// cpt_dly: fixed delay line
// Carries a word alongside the arithmetic pipelines through a chain of registers.
// ----------------------------------------------------------------------------
module cpt_dly #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] line_q [N];

	always_ff @(posedge clk) begin
		line_q[0] <= d;
		for (int k = 1; k < N; k++) begin
			line_q[k] <= line_q[k-1];
		end
	end

	assign q = line_q[N-1];

endmodule

// ===== sv/cpt_mul.sv =====
// ----------------------------------------------------------------------------
// cpt_mul: pipelined signed multiplier
// Takes one digit of b per stage, multiplies it by a and accumulates.
// ----------------------------------------------------------------------------
module cpt_mul #(
	parameter int AW = 8,
	parameter int BW = 8
) (
	input  logic                     clk,
	input  logic signed [AW-1:0]     a,
	input  logic signed [BW-1:0]     b,
	output logic signed [AW+BW-1:0]  p
);
	import cpt_pkg::*;

	localparam int NS = (BW + MUL_SW - 1) / MUL_SW;
	localparam int RW = AW + BW;

	logic signed [AW-1:0] a_s   [NS];
	logic signed [BW-1:0] b_s   [NS];
	logic signed [RW-1:0] acc_s [NS];

	for (genvar k = 0; k < NS; k++) begin : g_stage
		localparam int LO = k * MUL_SW;
		localparam int HI = (k == NS - 1) ? BW - 1 : LO + MUL_SW - 1;
		logic signed [AW-1:0]         a_in;
		logic signed [BW-1:0]         b_in;
		logic signed [RW-1:0]         acc_in;
		logic signed [HI-LO+1:0]      dig;
		logic signed [AW+HI-LO+1:0]   prod;

		if (k == 0) begin : g_first
			assign a_in = a;
			assign b_in = b;
			assign acc_in = '0;
		end else begin : g_next
			assign a_in = a_s[k-1];
			assign b_in = b_s[k-1];
			assign acc_in = acc_s[k-1];
		end

		if (k == NS - 1) begin : g_top
			assign dig = $signed({b_in[HI], b_in[HI:LO]});
		end else begin : g_low
			assign dig = $signed({1'b0, b_in[HI:LO]});
		end

		assign prod = a_in * dig;

		always_ff @(posedge clk) begin
			a_s[k] <= a_in;
			b_s[k] <= b_in;
			acc_s[k] <= acc_in + (RW'(prod) <<< LO);
		end
	end

	assign p = acc_s[NS-1];

endmodule

// ===== sv/cpt_div.sv =====
// ----------------------------------------------------------------------------
// cpt_div: pipelined floor divider and output adder
// Forms floor(num / (2*den)) with one quotient bit per stage, adds the base
// coordinate and saturates the sum to the coordinate range.
// ----------------------------------------------------------------------------
module cpt_div (
	input  logic                          clk,
	input  logic signed [cpt_pkg::NW-1:0] num,
	input  logic signed [cpt_pkg::PW-1:0] den,
	input  logic signed [cpt_pkg::XW-1:0] base,
	output logic signed [cpt_pkg::XW-1:0] coord
);
	import cpt_pkg::*;

	logic [NW-1:0]        m_c;
	logic [PW:0]          d2_c;

	logic [NW-1:0]        rem_s  [QW+1];
	logic [PW:0]          d2_s   [QW+1];
	logic [QW-1:0]        quo_s  [QW+1];
	logic                 neg_s  [QW+1];
	logic signed [XW-1:0] base_s [QW+1];

	logic signed [QW:0]   qs;
	logic signed [XW+3:0] sum;

	// A negative numerator is divided as a magnitude rounded up, which gives
	// the floor of the signed quotient.
	assign d2_c = {den[PW-1:0], 1'b0};
	assign m_c = num[NW-1] ? (NW'(-num) + NW'(d2_c) - NW'(1)) : $unsigned(num);

	always_ff @(posedge clk) begin
		rem_s[0] <= m_c;
		d2_s[0] <= d2_c;
		quo_s[0] <= '0;
		neg_s[0] <= num[NW-1];
		base_s[0] <= base;
	end

	for (genvar k = 1; k <= QW; k++) begin : g_step
		localparam int J = QW - k;
		logic [NW-1:0] trial;
		logic [NW:0]   diff;

		assign trial = NW'(d2_s[k-1]) << J;
		assign diff = {1'b0, rem_s[k-1]} - {1'b0, trial};

		always_ff @(posedge clk) begin
			rem_s[k] <= diff[NW] ? rem_s[k-1] : diff[NW-1:0];
			quo_s[k] <= {quo_s[k-1][QW-2:0], ~diff[NW]};
			d2_s[k] <= d2_s[k-1];
			neg_s[k] <= neg_s[k-1];
			base_s[k] <= base_s[k-1];
		end
	end

	assign qs = neg_s[QW] ? -$signed({1'b0, quo_s[QW]}) : $signed({1'b0, quo_s[QW]});
	assign sum = (XW+4)'(base_s[QW]) + (XW+4)'(qs);

	always_ff @(posedge clk) begin
		if (sum[XW+3:XW-1] == '0 || sum[XW+3:XW-1] == '1) begin
			coord <= sum[XW-1:0];
		end else begin
			coord <= {sum[XW+3], {(XW-1){~sum[XW+3]}}};
		end
	end

endmodule

// ===== sv/closest_point_on_triangle.sv =====
// ----------------------------------------------------------------------------
// closest_point_on_triangle: closest point of a 3-D triangle to a query point
//
// One item carries three vertices and a query point in signed Q16.16 on the
// query port; it is taken at a rising edge where start is high and busy is
// low. busy never rises, so an item may be offered in every cycle.
// Each item yields one result on the result port, marked by done for exactly
// one cycle. The exact integer path runs through the edge and dot product
// stages, the 67-bit digit-serial multipliers for det, s and t, the region
// selection, the parameter multipliers, the register forming the rounded
// numerator and the bit-per-stage divider with its output adder. Throughput
// is one item per cycle.
// Results leave in the order the items came in. The receiver cannot stall
// the block. Reset clears the valid pipeline, so no done strobe follows reset
// until an item has been taken.
// ----------------------------------------------------------------------------
module closest_point_on_triangle (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  cpt_pkg::cpt_in_t  query,
	output logic              done,
	output cpt_pkg::cpt_out_t result
);
	import cpt_pkg::*;

	localparam int NS2 = (DW + MUL_SW - 1) / MUL_SW;
	localparam int NS4 = (EW + MUL_SW - 1) / MUL_SW;
	localparam int LAT = 6 + NS2 + NS4 + QW + 2;
	localparam int SW4 = 7 * HW + 1;

	logic signed [XW-1:0] vin0 [3];
	logic signed [XW-1:0] vin1 [3];
	logic signed [XW-1:0] vin2 [3];
	logic signed [XW-1:0] vq   [3];

	logic [LAT-1:0] vld_q;

	logic signed [XW-1:0]   v0_s1 [3];
	logic signed [EW-1:0]   e0_s1 [3];
	logic signed [EW-1:0]   e1_s1 [3];
	logic signed [EW-1:0]   w_s1  [3];

	logic signed [2*EW-1:0] pa_s2 [3];
	logic signed [2*EW-1:0] pb_s2 [3];
	logic signed [2*EW-1:0] pc_s2 [3];
	logic signed [2*EW-1:0] pd_s2 [3];
	logic signed [2*EW-1:0] pe_s2 [3];

	logic signed [DW-1:0] a_s3, b_s3, c_s3, d_s3, e_s3;

	logic signed [2*DW-1:0] ac_p, bb_p, be_p, cd_p, bd_p, ae_p;

	logic signed [HW-1:0] dn_s4, en_s4, hnum_s4, hden_s4, g2_s4, a_s4, c_s4;
	logic                 negd_s4;
	logic [SW4-1:0]       s4_dly;
	logic signed [HW-1:0] dn_d, en_d, hnum_d, hden_d, g2_d, a_d, c_d;
	logic                 negd_d;

	logic signed [PW-1:0] det_s5, s_s5, t_s5;
	cpt_ratio_t           sd_s5, te_s5, h_s5;
	logic                 hgt_s5, g2gt_s5, negd_s5;

	logic                 lt, neg_s, neg_t;
	logic signed [HW-1:0] h_tn;
	logic signed [PW-1:0] sn_c, tn_c, den_c;
	logic signed [PW-1:0] sn_s6, tn_s6, den_s6;

	logic [6*EW-1:0]      e_dly;
	logic signed [EW-1:0] e0_s6 [3];
	logic signed [EW-1:0] e1_s6 [3];

	logic signed [PW+EW-1:0] ps_p [3];
	logic signed [PW+EW-1:0] pt_p [3];
	logic signed [PW-1:0]    den_d;
	logic [3*XW-1:0]         v0_dly;
	logic signed [XW-1:0]    v0_d [3];

	logic signed [NW-1:0] num_s7 [3];
	logic signed [PW-1:0] den_s7;
	logic signed [XW-1:0] v0_s7  [3];

	logic signed [XW-1:0] coord [3];

	assign busy = 1'b0;

	assign vin0[0] = query.vertex0_x;
	assign vin0[1] = query.vertex0_y;
	assign vin0[2] = query.vertex0_z;
	assign vin1[0] = query.vertex1_x;
	assign vin1[1] = query.vertex1_y;
	assign vin1[2] = query.vertex1_z;
	assign vin2[0] = query.vertex2_x;
	assign vin2[1] = query.vertex2_y;
	assign vin2[2] = query.vertex2_z;
	assign vq[0] = query.query_x;
	assign vq[1] = query.query_y;
	assign vq[2] = query.query_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start & ~busy};
		end
	end

	assign done = vld_q[LAT-1];

	// Edges and offset vector, then the five dot products.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			v0_s1[i] <= vin0[i];
			e0_s1[i] <= EW'(vin1[i]) - EW'(vin0[i]);
			e1_s1[i] <= EW'(vin2[i]) - EW'(vin0[i]);
			w_s1[i] <= EW'(vin0[i]) - EW'(vq[i]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			pa_s2[i] <= e0_s1[i] * e0_s1[i];
			pb_s2[i] <= e0_s1[i] * e1_s1[i];
			pc_s2[i] <= e1_s1[i] * e1_s1[i];
			pd_s2[i] <= e0_s1[i] * w_s1[i];
			pe_s2[i] <= e1_s1[i] * w_s1[i];
		end
	end

	always_ff @(posedge clk) begin
		a_s3 <= DW'(pa_s2[0]) + DW'(pa_s2[1]) + DW'(pa_s2[2]);
		b_s3 <= DW'(pb_s2[0]) + DW'(pb_s2[1]) + DW'(pb_s2[2]);
		c_s3 <= DW'(pc_s2[0]) + DW'(pc_s2[1]) + DW'(pc_s2[2]);
		d_s3 <= DW'(pd_s2[0]) + DW'(pd_s2[1]) + DW'(pd_s2[2]);
		e_s3 <= DW'(pe_s2[0]) + DW'(pe_s2[1]) + DW'(pe_s2[2]);
	end

	cpt_mul #(.AW(DW), .BW(DW)) u_mul_ac (.clk(clk), .a(a_s3), .b(c_s3), .p(ac_p));
	cpt_mul #(.AW(DW), .BW(DW)) u_mul_bb (.clk(clk), .a(b_s3), .b(b_s3), .p(bb_p));
	cpt_mul #(.AW(DW), .BW(DW)) u_mul_be (.clk(clk), .a(b_s3), .b(e_s3), .p(be_p));
	cpt_mul #(.AW(DW), .BW(DW)) u_mul_cd (.clk(clk), .a(c_s3), .b(d_s3), .p(cd_p));
	cpt_mul #(.AW(DW), .BW(DW)) u_mul_bd (.clk(clk), .a(b_s3), .b(d_s3), .p(bd_p));
	cpt_mul #(.AW(DW), .BW(DW)) u_mul_ae (.clk(clk), .a(a_s3), .b(e_s3), .p(ae_p));

	// Narrow sums for the edge clamps run beside the wide products.
	always_ff @(posedge clk) begin
		dn_s4 <= -HW'(d_s3);
		en_s4 <= -HW'(e_s3);
		hnum_s4 <= HW'(c_s3) + HW'(e_s3) - HW'(b_s3) - HW'(d_s3);
		hden_s4 <= HW'(a_s3) - (HW'(b_s3) <<< 1) + HW'(c_s3);
		g2_s4 <= HW'(a_s3) + HW'(d_s3) - HW'(b_s3) - HW'(e_s3);
		a_s4 <= HW'(a_s3);
		c_s4 <= HW'(c_s3);
		negd_s4 <= d_s3[DW-1];
	end

	cpt_dly #(.W(SW4), .N(NS2 - 1)) u_dly_s4 (
		.clk(clk),
		.d({dn_s4, en_s4, hnum_s4, hden_s4, g2_s4, a_s4, c_s4, negd_s4}),
		.q(s4_dly)
	);

	assign {dn_d, en_d, hnum_d, hden_d, g2_d, a_d, c_d, negd_d} = s4_dly;

	always_ff @(posedge clk) begin
		det_s5 <= PW'(ac_p) - PW'(bb_p);
		s_s5 <= PW'(be_p) - PW'(cd_p);
		t_s5 <= PW'(bd_p) - PW'(ae_p);
		sd_s5 <= clamp_ratio(dn_d, a_d);
		te_s5 <= clamp_ratio(en_d, c_d);
		h_s5 <= clamp_ratio(hnum_d, hden_d);
		hgt_s5 <= hnum_d > 0;
		g2gt_s5 <= g2_d > 0;
		negd_s5 <= negd_d;
	end

	// Region selection: vertex, edge, or interior of the triangle.
	always_comb begin
		lt = ((PW+1)'(s_s5) + (PW+1)'(t_s5)) < (PW+1)'(det_s5);
		neg_s = s_s5[PW-1];
		neg_t = t_s5[PW-1];
		h_tn = h_s5.den - h_s5.num;
		sn_c = PW'(h_s5.num);
		tn_c = PW'(h_tn);
		den_c = PW'(h_s5.den);
		if (lt) begin
			if (neg_s && neg_t && negd_s5) begin
				sn_c = PW'(sd_s5.num);
				tn_c = '0;
				den_c = PW'(sd_s5.den);
			end else if (neg_s) begin
				sn_c = '0;
				tn_c = PW'(te_s5.num);
				den_c = PW'(te_s5.den);
			end else if (neg_t) begin
				sn_c = PW'(sd_s5.num);
				tn_c = '0;
				den_c = PW'(sd_s5.den);
			end else begin
				sn_c = s_s5;
				tn_c = t_s5;
				den_c = det_s5;
			end
		end else begin
			if (neg_s) begin
				if (!hgt_s5) begin
					sn_c = '0;
					tn_c = PW'(te_s5.num);
					den_c = PW'(te_s5.den);
				end
			end else if (neg_t) begin
				if (!g2gt_s5) begin
					sn_c = PW'(sd_s5.num);
					tn_c = '0;
					den_c = PW'(sd_s5.den);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		sn_s6 <= sn_c;
		tn_s6 <= tn_c;
		den_s6 <= den_c;
	end

	cpt_dly #(.W(6*EW), .N(4 + NS2)) u_dly_e (
		.clk(clk),
		.d({e0_s1[0], e0_s1[1], e0_s1[2], e1_s1[0], e1_s1[1], e1_s1[2]}),
		.q(e_dly)
	);

	assign {e0_s6[0], e0_s6[1], e0_s6[2], e1_s6[0], e1_s6[1], e1_s6[2]} = e_dly;

	for (genvar i = 0; i < 3; i++) begin : g_axis
		cpt_mul #(.AW(PW), .BW(EW)) u_mul_s (
			.clk(clk), .a(sn_s6), .b(e0_s6[i]), .p(ps_p[i])
		);
		cpt_mul #(.AW(PW), .BW(EW)) u_mul_t (
			.clk(clk), .a(tn_s6), .b(e1_s6[i]), .p(pt_p[i])
		);
	end

	cpt_dly #(.W(PW), .N(NS4)) u_dly_den (
		.clk(clk),
		.d(den_s6),
		.q(den_d)
	);

	cpt_dly #(.W(3*XW), .N(4 + NS2 + NS4)) u_dly_v0 (
		.clk(clk),
		.d({v0_s1[0], v0_s1[1], v0_s1[2]}),
		.q(v0_dly)
	);

	assign {v0_d[0], v0_d[1], v0_d[2]} = v0_dly;

	// Numerator of the rounded offset: 2*(E0*sn + E1*tn) + den.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			num_s7[i] <= ((NW'(ps_p[i]) + NW'(pt_p[i])) <<< 1) + NW'(den_d);
			v0_s7[i] <= v0_d[i];
		end
		den_s7 <= den_d;
	end

	for (genvar i = 0; i < 3; i++) begin : g_div
		cpt_div u_div (
			.clk(clk),
			.num(num_s7[i]),
			.den(den_s7),
			.base(v0_s7[i]),
			.coord(coord[i])
		);
	end

	assign result.closest_x = coord[0];
	assign result.closest_y = coord[1];
	assign result.closest_z = coord[2];

endmodule
